>>> rtl/core/lph_pkg.sv
// Shared widths, operation codes and defaults for the linear-probe hash table.
package lph_pkg;

  localparam int KEY_W  = 32;
  localparam int VAL_W  = 32;
  localparam int SIZE_W = 6;
  localparam int MODE_W = 2;

  localparam int SLOTS_DEFAULT = 32;

  localparam logic [SIZE_W-1:0] RESET_TABLE_SIZE = 6'd20;
  localparam logic [SIZE_W-1:0] COUNT_MAX        = 6'd63;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NOP    = 2'd3;

endpackage

>>> rtl/core/lph_mod.sv
// Serial remainder unit: 32-bit magnitude modulo a 6-bit size, two bits per cycle.
module lph_mod (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [lph_pkg::KEY_W-1:0]  dividend,
  input  logic [lph_pkg::SIZE_W-1:0] divisor,
  output logic                       done,
  output logic [lph_pkg::SIZE_W-1:0] rem
);
  import lph_pkg::*;

  localparam int STEPS = KEY_W / 2;
  localparam int CW    = $clog2(STEPS);

  logic              busy;
  logic [CW-1:0]     count;
  logic [KEY_W-1:0]  shreg;
  logic [SIZE_W-1:0] dvs;

  logic [SIZE_W:0]   t1;
  logic [SIZE_W:0]   t2;
  logic [SIZE_W-1:0] r1;
  logic [SIZE_W-1:0] r2;

  // Two restoring steps per cycle; the partial remainder always stays below the divisor.
  always_comb begin
    t1 = {rem, shreg[KEY_W-1]};
    if (t1 >= {1'b0, dvs}) begin
      t1 = t1 - {1'b0, dvs};
    end
    r1 = t1[SIZE_W-1:0];
    t2 = {r1, shreg[KEY_W-2]};
    if (t2 >= {1'b0, dvs}) begin
      t2 = t2 - {1'b0, dvs};
    end
    r2 = t2[SIZE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + CW'(1);
        if (count == CW'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      dvs   <= divisor;
      rem   <= '0;
    end else if (busy) begin
      shreg <= {shreg[KEY_W-3:0], 2'b00};
      rem   <= r2;
    end
  end

endmodule

>>> rtl/core/linear_probe_hash_table_top.sv
// Linear-probe hash table: insert or update, lookup and clear over registered-read RAMs.
// Insert and lookup: the remainder unit forms the home slot from the key, the home slot is
// read, the slots are probed in turn (one up to the active table size of them), then the
// output word loads. Clear and the no-op code go straight to loading the output word.
// One word at a time: the input stalls until the result loads, and a result waits while
// the output is stalled. Reset (rst, synchronous) empties the table and sets size 20.
module linear_probe_hash_table_top #(
  parameter int SLOTS = lph_pkg::SLOTS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration: table size register.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lph_pkg::SIZE_W-1:0]        cfg_data,
  // Input channel.
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [lph_pkg::MODE_W-1:0]        mode,
  input  logic signed [lph_pkg::KEY_W-1:0]  key,
  input  logic signed [lph_pkg::VAL_W-1:0]  value,
  // Output channel.
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              found,
  output logic signed [lph_pkg::VAL_W-1:0]  value_out,
  output logic                              status
);
  import lph_pkg::*;

  // The size register never exceeds 63, so only the first 63 slots can ever be reached.
  localparam int USED = (SLOTS < 63) ? SLOTS : 63;
  localparam int IW   = $clog2(USED);
  localparam logic [SIZE_W-1:0] USED_W = SIZE_W'(USED);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_HASH  = 2'd1;
  localparam logic [1:0] S_PROBE = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]        state;
  logic [SIZE_W-1:0] table_size;
  logic [SIZE_W-1:0] entry_count;
  logic [USED-1:0]   slot_valid;

  // Key and value stores live in RAM; their read data is used only where the valid bit is set.
  logic [KEY_W-1:0]  slot_key   [USED];
  logic [VAL_W-1:0]  slot_value [USED];
  logic [KEY_W-1:0]  key_q;
  logic [VAL_W-1:0]  val_q;

  // Operation registers captured when a word is accepted.
  logic [MODE_W-1:0] mode_r;
  logic [KEY_W-1:0]  key_r;
  logic [VAL_W-1:0]  val_r;
  logic [SIZE_W-1:0] size_r;
  logic [IW-1:0]     idx;
  logic [SIZE_W-1:0] n;

  // Result waiting to be loaded into the output register.
  logic              res_found;
  logic [VAL_W-1:0]  res_vout;
  logic              res_status;

  logic              in_acc;
  logic [SIZE_W-1:0] size_eff;
  logic [KEY_W-1:0]  key_mag;
  logic              mod_start;
  logic              mod_done;
  logic [SIZE_W-1:0] mod_rem;

  logic [SIZE_W:0]   idx_p1;
  logic [IW-1:0]     idx_adv;
  logic [IW-1:0]     rd_addr;
  logic              cur_valid;
  logic              hit;
  logic              last;
  logic              key_we;
  logic              val_we;
  logic              out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // A size of zero acts as one, and a size beyond the slot count is held at the slot count.
  always_comb begin
    if (table_size == '0) begin
      size_eff = SIZE_W'(1);
    end else if (table_size > USED_W) begin
      size_eff = USED_W;
    end else begin
      size_eff = table_size;
    end
  end

  // The most negative key negates to itself, which read unsigned is 2^31 as required.
  assign key_mag   = key[KEY_W-1] ? (~key + KEY_W'(1)) : key;
  assign mod_start = in_acc && (mode == MODE_INSERT || mode == MODE_LOOKUP);

  lph_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (key_mag),
    .divisor  (size_eff),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // Next slot in probe order, wrapping at the active size.
  assign idx_p1  = (SIZE_W + 1)'(idx) + (SIZE_W + 1)'(1);
  assign idx_adv = (idx_p1 == {1'b0, size_r}) ? '0 : idx_p1[IW-1:0];

  // The read address runs one slot ahead: the home slot while hashing, the next slot while
  // probing, so that a new key and value are waiting on every probe cycle.
  assign rd_addr   = (state == S_HASH) ? mod_rem[IW-1:0] : idx_adv;
  assign cur_valid = slot_valid[idx];
  assign hit       = cur_valid && (key_q == key_r);
  assign last      = (n == size_r - SIZE_W'(1));

  // Writes happen only on the probe that ends an insert, after which the probe stops, so a
  // write never races a read that is still in flight.
  assign key_we = (state == S_PROBE) && (mode_r == MODE_INSERT) && !cur_valid;
  assign val_we = (state == S_PROBE) && (mode_r == MODE_INSERT) && (!cur_valid || hit);

  always_ff @(posedge clk) begin
    key_q <= slot_key[rd_addr];
    val_q <= slot_value[rd_addr];
    if (key_we) begin
      slot_key[idx] <= key_r;
    end
    if (val_we) begin
      slot_value[idx] <= val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= RESET_TABLE_SIZE;
    end else if (cfg_valid && cfg_ready) begin
      table_size <= cfg_data;
    end
  end

  // Control sequencer and the valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      slot_valid  <= '0;
      entry_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (mode == MODE_INSERT || mode == MODE_LOOKUP) begin
              state <= S_HASH;
            end else begin
              if (mode == MODE_CLEAR) begin
                slot_valid  <= '0;
                entry_count <= '0;
              end
              state <= S_DONE;
            end
          end
        end
        S_HASH: begin
          if (mod_done) begin
            state <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (!cur_valid || hit || last) begin
            state <= S_DONE;
          end
          if (key_we) begin
            slot_valid[idx] <= 1'b1;
            if (entry_count != COUNT_MAX) begin
              entry_count <= entry_count + SIZE_W'(1);
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Operation and result datapath.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r     <= mode;
      key_r      <= key;
      val_r      <= value;
      size_r     <= size_eff;
      res_found  <= 1'b0;
      res_vout   <= '0;
      res_status <= 1'b0;
    end
    if (state == S_HASH && mod_done) begin
      idx <= mod_rem[IW-1:0];
      n   <= '0;
    end
    if (state == S_PROBE) begin
      idx <= idx_adv;
      n   <= n + SIZE_W'(1);
      if (hit) begin
        res_found <= 1'b1;
        if (mode_r == MODE_LOOKUP) begin
          res_vout <= val_q;
        end
      end else if (cur_valid && last && mode_r == MODE_INSERT) begin
        // Every active slot holds another key: the insert is refused.
        res_status <= 1'b1;
      end
    end
    if (state == S_DONE && out_free) begin
      found     <= res_found;
      value_out <= res_vout;
      status    <= res_status;
    end
  end

endmodule

>>> verif/tb_linear_probe_hash_table_top.sv
// Self-checking testbench for the linear-probe hash table: directed cases, size sweeps, random.
`timescale 1ns / 100ps

module tb_linear_probe_hash_table_top;
  import lph_pkg::*;

  localparam int SLOTS         = SLOTS_DEFAULT;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_WORDS  = 1150;
  localparam int KEY_POOL_MAX  = 64;
  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // One result word as the block reports it.
  typedef struct packed {
    logic               found;
    logic [VAL_W-1:0]   value_out;
    logic               status;
  } table_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [SIZE_W-1:0] cfg_data  = '0;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [MODE_W-1:0] mode     = MODE_NOP;
  logic [KEY_W-1:0]  key      = '0;
  logic [VAL_W-1:0]  value    = '0;

  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              found;
  logic [VAL_W-1:0]  value_out;
  logic              status;

  linear_probe_hash_table_top #(.SLOTS(SLOTS)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .key       (key),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .found     (found),
    .value_out (value_out),
    .status    (status)
  );

  always #5 clk = ~clk;

  // Our own copy of the table contents and the size register.
  logic              occupied     [SLOTS];
  logic [KEY_W-1:0]  stored_key   [SLOTS];
  logic [VAL_W-1:0]  stored_value [SLOTS];
  logic [SIZE_W-1:0] entry_total;
  logic [SIZE_W-1:0] size_reg;

  table_reply_t      pending_replies [$];
  logic [KEY_W-1:0]  key_pool [$];

  int  error_count = 0;
  int  cycle_count = 0;
  int  hold_left   = 0;   // Long receiver hold-off requested by a test, in cycles.
  int  stall_burst = 0;
  bit  no_idle     = 1'b0; // When set, no gaps or random stalls are inserted; a requested hold-off still applies.
  bit  word_held   = 1'b0; // Mirrors whether in_valid is currently raised by us.

  // The effective slot count: a size of zero behaves as one slot, and anything past
  // the physical table is clamped to it.
  function automatic int unsigned active_slots();
    if (size_reg == 0) return 1;
    if (size_reg > SLOTS) return SLOTS;
    return 32'(size_reg);
  endfunction

  // Works out the reply to one operation and applies its effect on the table copy.
  function automatic table_reply_t predict_table_reply(logic [MODE_W-1:0] op,
                                                       logic [KEY_W-1:0] k,
                                                       logic [VAL_W-1:0] v);
    table_reply_t reply;
    int unsigned  sz;
    int unsigned  slot;
    int unsigned  n;
    logic [KEY_W-1:0] mag;
    bit           done;
    reply = '0;
    sz    = active_slots();
    // The most negative key negates to itself, which read as unsigned is 2^31.
    mag   = k[KEY_W-1] ? (~k + KEY_W'(1)) : k;
    slot  = mag % sz;
    done  = 1'b0;
    case (op)
      MODE_INSERT: begin
        for (n = 0; n < sz && !done; n++) begin
          if (!occupied[slot]) begin
            occupied[slot]     = 1'b1;
            stored_key[slot]   = k;
            stored_value[slot] = v;
            if (entry_total != COUNT_MAX) entry_total++;
            done = 1'b1;
          end else if (stored_key[slot] == k) begin
            stored_value[slot] = v;
            reply.found        = 1'b1;
            done               = 1'b1;
          end else begin
            slot = (slot + 1 == sz) ? 0 : slot + 1;
          end
        end
        reply.status = done ? STATUS_DONE : STATUS_FULL;
      end
      MODE_LOOKUP: begin
        for (n = 0; n < sz && !done; n++) begin
          if (!occupied[slot]) begin
            done = 1'b1;
          end else if (stored_key[slot] == k) begin
            reply.found     = 1'b1;
            reply.value_out = stored_value[slot];
            done            = 1'b1;
          end else begin
            slot = (slot + 1 == sz) ? 0 : slot + 1;
          end
        end
      end
      MODE_CLEAR: begin
        for (n = 0; n < SLOTS; n++) occupied[n] = 1'b0;
        entry_total = '0;
      end
      default: ;
    endcase
    return reply;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sends one word and records the reply it must produce once the block takes it.
  // Valid stays high between back-to-back words, so it is never dropped and raised
  // again within one step.
  task automatic issue_op(input logic [MODE_W-1:0] op, input logic [KEY_W-1:0] k,
                          input logic [VAL_W-1:0] v);
    int gap;
    gap = pick_gap();
    if (word_held && gap > 0) begin
      in_valid  <= 1'b0;
      word_held = 1'b0;
    end
    repeat (gap) @(posedge clk);
    in_valid  <= 1'b1;
    mode      <= op;
    key       <= k;
    value     <= v;
    word_held = 1'b1;
    do @(posedge clk); while (in_stall);
    pending_replies.push_back(predict_table_reply(op, k, v));
    if (op == MODE_INSERT) begin
      key_pool.push_back(k);
      if (key_pool.size() > KEY_POOL_MAX) void'(key_pool.pop_front());
    end
  endtask

  // Lets the block go idle: valid is dropped and every reply has come back.
  task automatic drain();
    if (word_held) begin
      in_valid  <= 1'b0;
      word_held = 1'b0;
    end
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes the size register while the block is idle.
  task automatic write_size(input logic [SIZE_W-1:0] sz);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= sz;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    size_reg  = sz;
    @(posedge clk);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45 && key_pool.size() > 0) return key_pool[$urandom_range(0, key_pool.size() - 1)];
    if (r < 75) return KEY_W'($signed($urandom_range(0, 160)) - 80);
    if (r < 80) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'hffff_ffff;
        default: return '0;
      endcase
    end
    return $urandom();
  endfunction

  // Field extremes, collisions, updates, every mode code and a clear, at the reset size.
  task automatic test_directed();
    issue_op(MODE_LOOKUP, 32'd0, 32'h1111_1111);        // Lookup on an empty table.
    issue_op(MODE_INSERT, 32'd0, 32'h7fff_ffff);
    issue_op(MODE_INSERT, 32'h8000_0000, 32'h8000_0000); // Most negative key.
    issue_op(MODE_INSERT, 32'h7fff_ffff, 32'hffff_ffff);
    issue_op(MODE_INSERT, 32'hffff_ffff, 32'h0000_0001); // Key -1 homes with key 1.
    issue_op(MODE_INSERT, 32'd1, 32'h5555_aaaa);         // Collides and probes on.
    issue_op(MODE_INSERT, 32'd1, 32'haaaa_5555);         // Updates in place.
    issue_op(MODE_LOOKUP, 32'd1, 32'h0);
    issue_op(MODE_LOOKUP, 32'hffff_ffff, 32'h0);
    issue_op(MODE_LOOKUP, 32'h8000_0000, 32'h0);
    issue_op(MODE_LOOKUP, 32'h7fff_ffff, 32'h0);
    issue_op(MODE_LOOKUP, 32'd21, 32'h0);                // Same home, absent.
    issue_op(MODE_LOOKUP, 32'hffff_ffec, 32'h0);         // Key -20 shares home with 0.
    issue_op(MODE_NOP, 32'hdead_beef, 32'hffff_ffff);
    issue_op(MODE_CLEAR, 32'hffff_ffff, 32'hffff_ffff);
    issue_op(MODE_LOOKUP, 32'd1, 32'h0);
    issue_op(MODE_LOOKUP, 32'd0, 32'h0);
    drain();
  endtask

  // For each size, fill every slot from one home so probing wraps, overflow it,
  // update inside a full table and miss after checking every slot.
  task automatic test_sizes();
    logic [SIZE_W-1:0] sizes [7] = '{6'd1, 6'd0, 6'd2, 6'd63, 6'd33, 6'd32, 6'd20};
    int unsigned       eff;
    logic [KEY_W-1:0]  k;
    foreach (sizes[s]) begin
      issue_op(MODE_CLEAR, '0, '0);
      write_size(sizes[s]);
      eff = active_slots();
      for (int unsigned i = 0; i <= eff; i++) begin
        k = i * eff + 3;
        issue_op(MODE_INSERT, i[0] ? -k : k, $urandom());
      end
      issue_op(MODE_INSERT, 32'd3, $urandom());
      for (int unsigned i = 0; i <= eff; i++) begin
        k = i * eff + 3;
        issue_op(MODE_LOOKUP, i[0] ? -k : k, '0);
      end
      issue_op(MODE_LOOKUP, 32'd100_003, '0);
    end
    drain();
  endtask

  // Shrinking without a clear hides entries past the new size until it grows again.
  task automatic test_resize_without_clear();
    issue_op(MODE_CLEAR, '0, '0);
    write_size(6'd32);
    for (int k = 25; k < 32; k++) issue_op(MODE_INSERT, k, k * 3);
    write_size(6'd8);
    issue_op(MODE_LOOKUP, 32'd25, '0);
    issue_op(MODE_INSERT, 32'd9, 32'h1234_5678);
    issue_op(MODE_LOOKUP, 32'd9, '0);
    write_size(6'd32);
    issue_op(MODE_LOOKUP, 32'd25, '0);
    issue_op(MODE_LOOKUP, 32'd9, '0);
    issue_op(MODE_LOOKUP, 32'd31, '0);
    drain();
  endtask

  // The receiver holds off for a long stretch while words keep coming, so the block
  // fills up and has to stall its input.
  task automatic test_backpressure();
    no_idle   = 1'b1;
    hold_left = 400;
    repeat (8) issue_op(($urandom_range(0, 1) == 0) ? MODE_INSERT : MODE_LOOKUP,
                        pick_key(), $urandom());
    no_idle = 1'b0;
    drain();
  endtask

  // Random phases at varied sizes, mostly inserts and lookups on a small key set so the
  // table collides and fills, with occasional clears, no-ops and fully random keys.
  task automatic test_random();
    int sent;
    int phase_len;
    int r;
    logic [SIZE_W-1:0] sz;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      if ($urandom_range(0, 1) == 0) issue_op(MODE_CLEAR, $urandom(), $urandom());
      r = $urandom_range(0, 99);
      if (r < 25)      sz = SIZE_W'($urandom_range(1, 4));
      else if (r < 40) sz = ($urandom_range(0, 2) == 0) ? 6'd0
                                                        : SIZE_W'($urandom_range(32, 63));
      else             sz = SIZE_W'($urandom_range(1, 32));
      write_size(sz);
      no_idle   = ($urandom_range(0, 4) == 0);
      phase_len = $urandom_range(60, 200);
      repeat (phase_len) begin
        r = $urandom_range(0, 99);
        if (r < 50)      issue_op(MODE_INSERT, pick_key(), $urandom());
        else if (r < 91) issue_op(MODE_LOOKUP, pick_key(), $urandom());
        else if (r < 94) issue_op(MODE_CLEAR, $urandom(), $urandom());
        else             issue_op(MODE_NOP, $urandom(), $urandom());
        sent++;
      end
      no_idle = 1'b0;
    end
    drain();
  endtask

  // Receiver side: random stall bursts, mostly short with a few long ones, plus any
  // long hold-off a test asks for.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall   <= 1'b1;
      stall_burst <= 0;
    end else if (no_idle) begin
      out_stall <= 1'b0;
    end else if (stall_burst > 0) begin
      stall_burst <= stall_burst - 1;
    end else begin
      out_stall   <= ($urandom_range(0, 99) < 30);
      stall_burst <= ($urandom_range(0, 99) < 95) ? $urandom_range(0, 3)
                                                  : $urandom_range(20, 80);
    end
  end

  task automatic report_field(input string name, input logic [VAL_W-1:0] want,
                              input logic [VAL_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  // Every accepted result word is compared with the oldest outstanding reply.
  always @(posedge clk) begin : check_replies
    table_reply_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: result word with none expected, found %0b value_out %0h status %0b",
                 $time, found, value_out, status);
        error_count++;
      end else begin
        want = pending_replies.pop_front();
        report_field("found", VAL_W'(want.found), VAL_W'(found));
        report_field("value_out", want.value_out, value_out);
        report_field("status", VAL_W'(want.status), VAL_W'(status));
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_linear_probe_hash_table_top failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      occupied[i]     = 1'b0;
      stored_key[i]   = '0;
      stored_value[i] = '0;
    end
    entry_total = '0;
    size_reg    = RESET_TABLE_SIZE;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_sizes();
    test_resize_without_clear();
    test_backpressure();
    test_random();

    // Allow any stray word from a slow full-table probe to show up.
    repeat (SLOTS + 40) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_linear_probe_hash_table_top passed");
    end else begin
      $display("tb_linear_probe_hash_table_top failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/lph_pkg.sv
rtl/core/lph_mod.sv
rtl/core/linear_probe_hash_table_top.sv
verif/tb_linear_probe_hash_table_top.sv
